### sv/brlc_pkg.sv
package brlc_pkg;

  // Geometry of the filter.
  localparam int DELAY_DEPTH = 52;
  localparam int CHANNELS    = 3;
  localparam int LEN_W       = 6;
  localparam int RUN_LEN_MAX = (1 << LEN_W) - 1;
  localparam int MODE_W      = 2;
  localparam int LEVEL_W     = 32;
  localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int IDX_W       = $clog2(DELAY_DEPTH);

  // The level word is delayed through both lines: one shared circular buffer per channel.
  localparam int LVL_DEPTH   = 2 * (DELAY_DEPTH - 1);
  localparam int PTR_W       = $clog2(LVL_DEPTH);
  localparam int LVL_AW      = CH_W + PTR_W;
  localparam int LVL_ENTRIES = CHANNELS << PTR_W;

  // Stream word widths, padded to whole bytes.
  localparam int IN_TDATA_W  = ((1 + LEVEL_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((1 + LEVEL_W + 7) / 8) * 8;

  // Register file.
  localparam int APB_AW      = 3;
  localparam int APB_DW      = 32;
  localparam logic [LEN_W-1:0] SEG_LEN_RST = LEN_W'(50);
  localparam logic [LEN_W-1:0] GAP_LEN_RST = LEN_W'(25);
  localparam logic REG_MIN_SEG = 1'b0;
  localparam logic REG_MIN_GAP = 1'b1;

  // Access request to the level delay buffer.
  typedef struct packed {
    logic            rd;
    logic [CH_W-1:0] rd_ch;
    logic            wr;
    logic [CH_W-1:0] wr_ch;
  } lvl_ctl_t;

endpackage

### sv/brlc_level_delay.sv
module brlc_level_delay (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  brlc_pkg::lvl_ctl_t              ctl_i,
  input  logic [brlc_pkg::LEVEL_W-1:0]    wdata_i,
  output logic [brlc_pkg::LEVEL_W-1:0]    rdata_o
);
  import brlc_pkg::*;

  logic [LEVEL_W-1:0] mem [LVL_ENTRIES];
  logic [PTR_W-1:0]   ptr_q [CHANNELS];
  logic               wrap_q [CHANNELS];
  logic [LEVEL_W-1:0] rd_data_q;
  logic               rd_ok_q;
  logic [LVL_AW-1:0]  raddr;
  logic [LVL_AW-1:0]  waddr;

  assign raddr = {ctl_i.rd_ch, ptr_q[ctl_i.rd_ch]};
  assign waddr = {ctl_i.wr_ch, ptr_q[ctl_i.wr_ch]};

  // Oldest word of the channel is read before the new word takes its place.
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd) begin
      rd_data_q <= mem[raddr];
    end
    if (ctl_i.wr) begin
      mem[waddr] <= wdata_i;
    end
  end

  // Write pointers; an entry counts as written once its channel has wrapped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        ptr_q[c]  <= '0;
        wrap_q[c] <= 1'b0;
      end
      rd_ok_q <= 1'b0;
    end else begin
      if (ctl_i.rd) begin
        rd_ok_q <= wrap_q[ctl_i.rd_ch];
      end
      if (ctl_i.wr) begin
        if (ptr_q[ctl_i.wr_ch] == PTR_W'(LVL_DEPTH - 1)) begin
          ptr_q[ctl_i.wr_ch]  <= '0;
          wrap_q[ctl_i.wr_ch] <= 1'b1;
        end else begin
          ptr_q[ctl_i.wr_ch] <= ptr_q[ctl_i.wr_ch] + PTR_W'(1);
        end
      end
    end
  end

  // Entries never written read as zero.
  assign rdata_o = rd_ok_q ? rd_data_q : '0;

endmodule

### sv/binary_run_length_cleanup.sv
// Minimum run-length cleanup of a binary segmentation stream on three channels. Each input
// word carries a channel in tuser and a segmentation bit plus a 32-bit level word in tdata;
// each one yields exactly one output word with the cleaned bit and the level word, delayed
// by 51 samples of the same channel in each of two stages (102 samples in all, zeros until
// the channel has filled). Stage one clears closed runs of ones shorter than min_segment_len
// (address 0x0), stage two fills closed runs of zeros shorter than min_gap_len (address 0x4).
// For each sample, stage one and stage two each rewrite the line positions of a run that
// just closed short (none otherwise, at most 51 each). A single fill walker, which
// rewrites one delay-line position per cycle, serves both stages. An output register
// holds the finished word, so a new input word is taken while the result waits.
module binary_run_length_cleanup (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration port.
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [brlc_pkg::APB_AW-1:0]         paddr,
  input  logic [brlc_pkg::APB_DW-1:0]         pwdata,
  output logic [brlc_pkg::APB_DW-1:0]         prdata,
  output logic                                pready,
  // Input stream.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: seg_in [0], level_in [32:1], zero padding above.
  input  logic [brlc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // tuser: mode [1:0].
  input  logic [brlc_pkg::MODE_W-1:0]         s_axis_tuser,
  // Output stream.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata: seg_out [0], level_out [32:1], zero padding above.
  output logic [brlc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
  import brlc_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ST1   = 3'd1;
  localparam logic [2:0] S_FILL1 = 3'd2;
  localparam logic [2:0] S_ST2   = 3'd3;
  localparam logic [2:0] S_FILL2 = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]             state_q;
  logic [CH_W-1:0]        ch_q;
  logic                   bit_q;
  logic [LEVEL_W-1:0]     word_q;
  logic [DELAY_DEPTH-1:0] line1_q [CHANNELS];
  logic [DELAY_DEPTH-1:0] line2_q [CHANNELS];
  logic                   act1_q [CHANNELS];
  logic                   act2_q [CHANNELS];
  logic [LEN_W-1:0]       len1_q [CHANNELS];
  logic [LEN_W-1:0]       len2_q [CHANNELS];
  logic [IDX_W-1:0]       fill_idx_q;
  logic [LEN_W-1:0]       fill_cnt_q;
  logic [LEN_W-1:0]       min_seg_q;
  logic [LEN_W-1:0]       min_gap_q;
  logic                   out_valid_q;
  logic                   out_seg_q;
  logic [LEVEL_W-1:0]     out_lvl_q;

  logic                   s_accept;
  logic                   out_load;
  logic                   cfg_we;
  logic [CH_W-1:0]        ch_sel;
  logic [LEVEL_W-1:0]     lvl_rdata;
  lvl_ctl_t               lvl_ctl;

  logic                   stage2;
  logic                   trk_bit;
  logic [LEN_W-1:0]       trk_thr;
  logic                   trk_act;
  logic [LEN_W-1:0]       trk_len;
  logic                   trk_in;
  logic                   trk_act_d;
  logic [LEN_W-1:0]       trk_len_d;
  logic                   trk_fill;
  logic [LEN_W-1:0]       trk_cnt;

  // Register file: always ready, index taken from the word address.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_seg_q <= SEG_LEN_RST;
      min_gap_q <= GAP_LEN_RST;
    end else if (cfg_we) begin
      unique case (paddr[2])
        REG_MIN_SEG: min_seg_q <= pwdata[LEN_W-1:0];
        REG_MIN_GAP: min_gap_q <= pwdata[LEN_W-1:0];
        default:     min_seg_q <= min_seg_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MIN_SEG: prdata = {{(APB_DW - LEN_W){1'b0}}, min_seg_q};
      REG_MIN_GAP: prdata = {{(APB_DW - LEN_W){1'b0}}, min_gap_q};
      default:     prdata = '0;
    endcase
  end

  // Handshake and channel select; out-of-range modes go to the last channel.
  assign s_axis_tready = (state_q == S_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign ch_sel        = (s_axis_tuser >= MODE_W'(CHANNELS - 1)) ? CH_W'(CHANNELS - 1)
                                                                  : CH_W'(s_axis_tuser);
  assign out_load      = (state_q == S_OUT) && (!out_valid_q || m_axis_tready);

  // Level words travel through a circular buffer.
  assign lvl_ctl.rd    = s_accept;
  assign lvl_ctl.rd_ch = ch_sel;
  assign lvl_ctl.wr    = (state_q == S_ST1);
  assign lvl_ctl.wr_ch = ch_q;

  brlc_level_delay u_level_delay (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (lvl_ctl),
    .wdata_i (word_q),
    .rdata_o (lvl_rdata)
  );

  // Shared run tracker: stage one tracks ones, stage two tracks zeros.
  assign stage2  = (state_q == S_ST2);
  assign trk_bit = !stage2;
  assign trk_thr = stage2 ? min_gap_q : min_seg_q;
  assign trk_act = stage2 ? act2_q[ch_q] : act1_q[ch_q];
  assign trk_len = stage2 ? len2_q[ch_q] : len1_q[ch_q];
  assign trk_in  = stage2 ? line1_q[ch_q][0] : bit_q;

  always_comb begin
    trk_act_d = trk_act;
    trk_len_d = trk_len;
    trk_fill  = 1'b0;
    if (!trk_act) begin
      trk_act_d = (trk_in == trk_bit);
      trk_len_d = (trk_in == trk_bit) ? LEN_W'(1) : '0;
    end else if (trk_in == trk_bit) begin
      if (trk_len != LEN_W'(RUN_LEN_MAX)) begin
        trk_len_d = trk_len + LEN_W'(1);
      end
    end else begin
      trk_act_d = 1'b0;
      trk_fill  = (trk_len < trk_thr) && (trk_len != '0);
    end
    // Positions to rewrite stop at the oldest entry of the line.
    trk_cnt = (trk_len > LEN_W'(DELAY_DEPTH - 1)) ? LEN_W'(DELAY_DEPTH - 1) : trk_len;
  end

  // Sequencer: shift stage one, walk its fill, shift stage two, walk its fill, emit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      ch_q       <= '0;
      fill_idx_q <= '0;
      fill_cnt_q <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        line1_q[c] <= '0;
        line2_q[c] <= '0;
        act1_q[c]  <= 1'b0;
        act2_q[c]  <= 1'b0;
        len1_q[c]  <= '0;
        len2_q[c]  <= '0;
      end
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (s_accept) begin
            ch_q    <= ch_sel;
            state_q <= S_ST1;
          end
        end
        S_ST1: begin
          line1_q[ch_q] <= {bit_q, line1_q[ch_q][DELAY_DEPTH-1:1]};
          act1_q[ch_q]  <= trk_act_d;
          len1_q[ch_q]  <= trk_len_d;
          fill_idx_q    <= IDX_W'(DELAY_DEPTH - 2);
          fill_cnt_q    <= trk_cnt;
          state_q       <= trk_fill ? S_FILL1 : S_ST2;
        end
        S_FILL1: begin
          line1_q[ch_q][fill_idx_q] <= 1'b0;
          fill_idx_q <= fill_idx_q - IDX_W'(1);
          fill_cnt_q <= fill_cnt_q - LEN_W'(1);
          if (fill_cnt_q == LEN_W'(1)) begin
            state_q <= S_ST2;
          end
        end
        S_ST2: begin
          line2_q[ch_q] <= {line1_q[ch_q][0], line2_q[ch_q][DELAY_DEPTH-1:1]};
          act2_q[ch_q]  <= trk_act_d;
          len2_q[ch_q]  <= trk_len_d;
          fill_idx_q    <= IDX_W'(DELAY_DEPTH - 2);
          fill_cnt_q    <= trk_cnt;
          state_q       <= trk_fill ? S_FILL2 : S_OUT;
        end
        S_FILL2: begin
          line2_q[ch_q][fill_idx_q] <= 1'b1;
          fill_idx_q <= fill_idx_q - IDX_W'(1);
          fill_cnt_q <= fill_cnt_q - LEN_W'(1);
          if (fill_cnt_q == LEN_W'(1)) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Input sample held for the duration of the word.
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      bit_q  <= s_axis_tdata[0];
      word_q <= s_axis_tdata[LEVEL_W:1];
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_seg_q <= line2_q[ch_q][0];
      out_lvl_q <= lvl_rdata;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W - LEVEL_W - 1){1'b0}}, out_lvl_q, out_seg_q};

  // A fill walk never starts with nothing to rewrite.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FILL1 || state_q == S_FILL2) |-> fill_cnt_q != '0)
    else $error("fill walk with zero count");

  // An open run always has a length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (act1_q[ch_q] |-> len1_q[ch_q] != '0) and (act2_q[ch_q] |-> len2_q[ch_q] != '0))
    else $error("open run with zero length");

  // One word at a time: the input closes right after a word is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> !s_axis_tready)
    else $error("input taken while a word is in progress");

  // A result appears only from the emit step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q) == S_OUT)
    else $error("output valid without emit step");

endmodule

### verif/tb_binary_run_length_cleanup.sv
module tb_binary_run_length_cleanup;
  timeunit 1ns;
  timeprecision 1ps;

  import brlc_pkg::*;

  localparam int NUM_PHASES      = 7;
  localparam int ITEMS_PER_PHASE = 183;
  localparam int IDLE_PCT        = 16;
  localparam int HOLD_CYCLES     = 400;
  localparam int DRAIN_CYCLES    = 120;
  localparam int QUIET_LIMIT     = 4000;
  localparam int PRINT_LIMIT     = 100;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic               seg;
    logic [LEVEL_W-1:0] level;
  } sample_in_t;

  typedef struct packed {
    logic               seg;
    logic [LEVEL_W-1:0] level;
  } sample_out_t;

  // Clock, reset and block ports.
  logic                   clk_i = 1'b1;
  logic                   rst_ni = 1'b0;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [APB_AW-1:0]      paddr = '0;
  logic [APB_DW-1:0]      pwdata = '0;
  logic [APB_DW-1:0]      prdata;
  logic                   pready;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // tdata: seg_in [0], level_in [32:1], zero padding above.
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  // tuser: mode [1:0].
  logic [MODE_W-1:0]      s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // tdata: seg_out [0], level_out [32:1], zero padding above.
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // Shadow state of both filter stages, all channels; 2-state so it starts cleared.
  bit             line_bit   [2][CHANNELS][DELAY_DEPTH];
  bit [31:0]      line_level [2][CHANNELS][DELAY_DEPTH];
  bit             run_open   [2][CHANNELS];
  bit [LEN_W-1:0] run_count  [2][CHANNELS];
  bit [LEN_W-1:0] min_len    [2] = '{SEG_LEN_RST, GAP_LEN_RST};

  // Words waiting to be offered and cleaned results still owed by the block.
  sample_in_t  samples_to_send [$];
  sample_out_t cleaned_due [$];
  sample_in_t  next_word;

  // Run shape of the random generator, per channel.
  bit run_bit  [CHANNELS];
  int run_left [CHANNELS];

  int seg_setting [NUM_PHASES] = '{50, 1, 51, 0, 63, 4, 17};
  int gap_setting [NUM_PHASES] = '{25, 1, 51, 63, 0, 7, 33};

  int  n_queued;
  int  n_taken;
  int  n_results;
  int  n_ones;
  int  n_saturated;
  int  n_rewrites [2];
  int  errors;
  int  quiet_cycles;
  int  hold_left;
  bit  hold_armed;
  bit  hold_done;
  bit  steady;
  bit  in_fire;
  int  ph;

  binary_run_length_cleanup DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // One stage: shift the line, track the open run, rewrite a short run once it closes.
  function automatic sample_out_t filter_stage(input int st, input int ch, input sample_out_t din);
    bit          tracked;
    int          i;
    int          first;
    sample_out_t dout;
    tracked = (st == 0);
    for (i = 0; i < DELAY_DEPTH - 1; i++) begin
      line_bit[st][ch][i]   = line_bit[st][ch][i + 1];
      line_level[st][ch][i] = line_level[st][ch][i + 1];
    end
    line_bit[st][ch][DELAY_DEPTH - 1]   = din.seg;
    line_level[st][ch][DELAY_DEPTH - 1] = din.level;
    if (!run_open[st][ch]) begin
      run_open[st][ch]  = (din.seg == tracked);
      run_count[st][ch] = (din.seg == tracked) ? LEN_W'(1) : LEN_W'(0);
    end else if (din.seg == tracked) begin
      if (run_count[st][ch] < RUN_LEN_MAX) begin
        run_count[st][ch] += 1'b1;
        if (run_count[st][ch] == RUN_LEN_MAX) begin
          n_saturated++;
        end
      end
    end else begin
      if (run_count[st][ch] < min_len[st]) begin
        // Positions of the run that already left the line stay as they were.
        first = (DELAY_DEPTH - 1) - int'(run_count[st][ch]);
        if (first < 0) begin
          first = 0;
        end
        for (i = first; i < DELAY_DEPTH - 1; i++) begin
          line_bit[st][ch][i] = !tracked;
        end
        n_rewrites[st]++;
      end
      run_open[st][ch] = 1'b0;
    end
    dout.seg   = line_bit[st][ch][0];
    dout.level = line_level[st][ch][0];
    return dout;
  endfunction

  // Cleaned word for one input word: stage one feeds stage two of the same channel.
  function automatic sample_out_t predict_cleaned(input sample_in_t s);
    int          ch;
    sample_out_t mid;
    ch         = (s.mode >= CHANNELS) ? CHANNELS - 1 : int'(s.mode);
    mid.seg    = s.seg;
    mid.level  = s.level;
    mid        = filter_stage(0, ch, mid);
    return filter_stage(1, ch, mid);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    if (errors <= PRINT_LIMIT) begin
      $display("ERROR at %0t ns: %s is %h, should be %h", $time, what, got, want);
    end
  endtask

  task automatic check_result(input logic [OUT_TDATA_W-1:0] word);
    sample_out_t want;
    if (cleaned_due.size() == 0) begin
      report_mismatch("level_out of a word nobody asked for", word[LEVEL_W:1], '0);
    end else begin
      want = cleaned_due.pop_front();
      n_results++;
      if (word[0] === 1'b1) begin
        n_ones++;
      end
      if (word[0] !== want.seg) begin
        report_mismatch("seg_out", 32'(word[0]), 32'(want.seg));
      end
      if (word[LEVEL_W:1] !== want.level) begin
        report_mismatch("level_out", word[LEVEL_W:1], want.level);
      end
    end
  endtask

  task automatic push_sample(input logic [MODE_W-1:0] mode, input logic seg,
                             input logic [LEVEL_W-1:0] level);
    sample_in_t s;
    s.mode  = mode;
    s.seg   = seg;
    s.level = level;
    samples_to_send.push_back(s);
    n_queued++;
  endtask

  // One setup and one access cycle on the register port.
  task automatic apb_access(input logic wr, input logic idx, input logic [APB_DW-1:0] wdata,
                            output logic [APB_DW-1:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Upper data bits carry junk that the register must drop.
  task automatic set_threshold(input logic idx, input logic [LEN_W-1:0] value);
    logic [APB_DW-1:0] junk;
    logic [APB_DW-1:0] rdata;
    junk = $urandom();
    apb_access(1'b1, idx, {junk[APB_DW-1:LEN_W], value}, rdata);
    min_len[idx] = value;
  endtask

  task automatic verify_threshold(input logic idx);
    logic [APB_DW-1:0] rdata;
    apb_access(1'b0, idx, '0, rdata);
    if (rdata !== APB_DW'(min_len[idx])) begin
      report_mismatch(idx == REG_MIN_SEG ? "min_segment_len readback" : "min_gap_len readback",
                      rdata, APB_DW'(min_len[idx]));
    end
  endtask

  // Extremes of the fields, every channel including the folded mode, short runs both ways.
  task automatic queue_directed();
    push_sample(2'd0, 1'b1, 32'h0000_0000);
    push_sample(2'd0, 1'b0, 32'hFFFF_FFFF);
    push_sample(2'd1, 1'b0, 32'hFFFF_FFFF);
    push_sample(2'd1, 1'b1, 32'h0000_0000);
    push_sample(2'd1, 1'b1, 32'hAAAA_AAAA);
    push_sample(2'd1, 1'b0, 32'h5555_5555);
    push_sample(2'd2, 1'b1, 32'h5555_5555);
    push_sample(2'd3, 1'b1, 32'hAAAA_AAAA);
    push_sample(2'd3, 1'b0, 32'h8000_0001);
    push_sample(2'd2, 1'b0, 32'h7FFF_FFFE);
    push_sample(2'd3, 1'b1, 32'hFFFF_FFFF);
    push_sample(2'd0, 1'b1, 32'h0000_0001);
    push_sample(2'd0, 1'b1, 32'h8000_0000);
    push_sample(2'd0, 1'b0, 32'h0000_0000);
    push_sample(2'd2, 1'b0, 32'hFFFF_FFFF);
    push_sample(2'd3, 1'b0, 32'h0000_0000);
  endtask

  // Runs of alternating bits per channel: many short, many near the threshold, some
  // longer than the line and past the length ceiling, with an occasional stray bit.
  task automatic queue_random(input int count);
    int                 k;
    int                 ch;
    int                 pick;
    int                 thr;
    logic [MODE_W-1:0]  mode;
    logic               seg;
    logic [LEVEL_W-1:0] level;
    for (k = 0; k < count; k++) begin
      mode = MODE_W'($urandom_range(0, 3));
      ch   = (mode >= CHANNELS) ? CHANNELS - 1 : int'(mode);
      if (run_left[ch] == 0) begin
        run_bit[ch] = !run_bit[ch];
        thr  = run_bit[ch] ? int'(min_len[0]) : int'(min_len[1]);
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          run_left[ch] = $urandom_range(1, 8);
        end else if (pick < 85) begin
          run_left[ch] = (thr > 2) ? $urandom_range(thr - 2, thr + 2) : $urandom_range(1, 4);
        end else begin
          run_left[ch] = $urandom_range(52, 90);
        end
      end
      run_left[ch]--;
      seg = run_bit[ch];
      if ($urandom_range(0, 99) < 4) begin
        seg = !seg;
      end
      pick = $urandom_range(0, 9);
      level = (pick == 0) ? '0 : (pick == 1) ? '1 : LEVEL_W'($urandom());
      push_sample(mode, seg, level);
    end
  endtask

  task automatic wait_drained();
    while (n_taken != n_queued || cleaned_due.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // Sender: offers the queued words, idling now and then.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || in_fire) begin
        if (samples_to_send.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
          next_word     = samples_to_send.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= next_word.mode;
          s_axis_tdata  <= {{(IN_TDATA_W - 1 - LEVEL_W){1'b0}}, next_word.level, next_word.seg};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off so the block backs up.
  always @(negedge clk_i) begin
    if (hold_armed && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Monitor: check outgoing words, then predict for the word taken at this edge.
  always @(posedge clk_i) begin
    in_fire <= s_axis_tvalid && (s_axis_tready === 1'b1);
    if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
      check_result(m_axis_tdata);
    end
    if (s_axis_tvalid && s_axis_tready === 1'b1) begin
      cleaned_due.push_back(predict_cleaned({s_axis_tuser, s_axis_tdata[0],
                                             s_axis_tdata[LEVEL_W:1]}));
      n_taken++;
    end
  end

  // Watchdog on cycles in which no word and no register access moves.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready === 1'b1) ||
        (m_axis_tvalid === 1'b1 && m_axis_tready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timed out after %0d quiet cycles with %0d results owed",
               quiet_cycles, cleaned_due.size());
      $display("binary_run_length_cleanup: mismatch");
      $finish;
    end
  end

  // Phases: reset thresholds first, then each new setting written while the block is idle.
  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) begin
        set_threshold(REG_MIN_SEG, LEN_W'(seg_setting[ph]));
        set_threshold(REG_MIN_GAP, LEN_W'(gap_setting[ph]));
      end
      verify_threshold(REG_MIN_SEG);
      verify_threshold(REG_MIN_GAP);
      steady     = (ph == 2);
      hold_armed = (ph == 3);
      if (ph == 0) begin
        queue_directed();
      end
      queue_random(ITEMS_PER_PHASE);
      wait_drained();
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (cleaned_due.size() != 0) begin
      report_mismatch("count of results never delivered", cleaned_due.size(), 0);
    end
    $display("Checked %0d cleaned words (%0d with the bit set) on all channels over %0d",
             n_results, n_ones, NUM_PHASES);
    $display("threshold settings; %0d short runs cleared, %0d short gaps filled, %0d at ceiling",
             n_rewrites[0], n_rewrites[1], n_saturated);
    if (errors == 0) begin
      $display("binary_run_length_cleanup: match");
    end else begin
      $display("binary_run_length_cleanup: mismatch");
    end
    $finish;
  end

endmodule

### files.f
sv/brlc_pkg.sv
sv/brlc_level_delay.sv
sv/binary_run_length_cleanup.sv
verif/tb_binary_run_length_cleanup.sv
